>>> design/lru_cache_pkg.sv
`timescale 1ns / 1ps
package lru_cache_pkg;
	localparam int ENTRIES_DEF = 16;
	localparam int BLOCK_BYTES_DEF = 4096;
	localparam int DEVICES_DEF = 16;

	typedef enum logic [1:0] {
		CMD_READ = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_SYNC = 2'd2,
		CMD_FAIL = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_HIT = 3'd0,
		ST_MISS = 3'd1,
		ST_BAD = 3'd2,
		ST_SYNC_WB = 3'd3,
		ST_SYNC_DONE = 3'd4,
		ST_INVAL = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_SYNC,
		S_OUT
	} state_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic [3:0]  dev;
		logic [31:0] blk;
		logic        upd;        // apply recency/valid update this cycle
		logic        set_dirty;
		logic        alloc;      // selected cell takes the new tag
		logic        inval;      // selected cell is invalidated
		logic        clr_dirty;  // selected cell drops dirty (sync)
		logic [5:0]  sel;        // selected cell index
		logic [5:0]  ref_rank;   // rank of the selected cell before update
		logic        sel_was_valid;
	} cell_ctl_t;

	// Per-cell view back to the controller.
	typedef struct packed {
		logic        valid;
		logic        dirty;
		logic        match;
		logic [3:0]  dev;
		logic [31:0] blk;
		logic [5:0]  rank;
	} cell_stat_t;
endpackage

>>> design/lru_cache_cell.sv
`timescale 1ns / 1ps
module lru_cache_cell
	import lru_cache_pkg::*;
#(
	parameter int IDX = 0,
	parameter int RW = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	output cell_stat_t stat
);
	logic          valid_q, dirty_q;
	logic [3:0]    dev_q;
	logic [31:0]   blk_q;
	logic [RW-1:0] rank_q;
	logic          me;

	assign me = (ctl.sel[RW-1:0] == IDX[RW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			rank_q <= '0;
		end else if (ctl.upd) begin
			if (me && ctl.alloc) begin
				valid_q <= 1'b1;
				dirty_q <= ctl.set_dirty | (dirty_q & valid_q & !ctl.alloc);
				rank_q <= '0;
			end else if (me && ctl.inval) begin
				valid_q <= 1'b0;
				dirty_q <= 1'b0;
				rank_q <= '0;
			end else if (me && ctl.clr_dirty) begin
				dirty_q <= 1'b0;
			end else if (me) begin
				// Hit: becomes most recent.
				rank_q <= '0;
				if (ctl.set_dirty) dirty_q <= 1'b1;
			end else if (valid_q) begin
				if (ctl.inval) begin
					if (ctl.sel_was_valid && rank_q > ctl.ref_rank[RW-1:0])
						rank_q <= rank_q - 1'b1;
				end else if (!ctl.clr_dirty) begin
					if (!ctl.sel_was_valid || rank_q < ctl.ref_rank[RW-1:0])
						rank_q <= rank_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd && me && ctl.alloc) begin
			dev_q <= ctl.dev;
			blk_q <= ctl.blk;
		end
	end

	always_comb begin
		stat.valid = valid_q;
		stat.dirty = dirty_q;
		stat.match = valid_q && dev_q == ctl.dev && blk_q == ctl.blk;
		stat.dev = dev_q;
		stat.blk = blk_q;
		stat.rank = 6'(rank_q);
	end
endmodule

>>> design/lru_write_back_block_cache_tags_unit.sv
`timescale 1ns / 1ps
// Read, write and fill-failed items: the result is registered in the lookup state after
// the item is accepted, and the next item is taken only after the result leaves.
// Only one item is in flight.
// Sync: a scan over all ENTRIES slots that issues writebacks as found, then the done
// item; the scan holds while a result item is stalled at the output.
// Reset (arst_n low) clears valid, dirty and ranks of all slots at once.
module lru_write_back_block_cache_tags_unit
	import lru_cache_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	parameter int DEVICES = DEVICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [3:0]  device_id,
	input  logic [31:0] block_number,
	input  logic [15:0] length,
	input  logic        sync_all,
	input  logic [3:0]  failed_slot,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [3:0]  slot,
	output logic        hit,
	output logic        fetch_needed,
	output logic        victim_writeback,
	output logic [3:0]  victim_device,
	output logic [31:0] victim_block,
	output logic [4:0]  flush_count,
	output logic [15:0] bytes_done,
	output logic        last
);
	localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES + 1) : 1;
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	state_t state_q, state_d;
	cell_ctl_t ctl;
	cell_stat_t st [ENTRIES];

	logic [1:0]  cmd_q;
	logic [3:0]  dev_q, fs_q;
	logic [31:0] blk_q;
	logic [15:0] len_q;
	logic        all_q;
	logic [IW-1:0] scan_q;
	logic [4:0]  cnt_q;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lru_cache_cell #(.IDX(g), .RW(RW)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .stat(st[g])
		);
	end

	// Lookup: parallel match, lowest free slot, oldest valid slot.
	logic        any_hit, any_free;
	logic [IW-1:0] hit_i, free_i, old_i, pick_i;
	always_comb begin
		any_hit = 1'b0; any_free = 1'b0;
		hit_i = '0; free_i = '0; old_i = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (st[i].match) begin any_hit = 1'b1; hit_i = IW'(i); end
			if (!st[i].valid) begin any_free = 1'b1; free_i = IW'(i); end
			if (st[i].rank == 6'(ENTRIES - 1)) old_i = IW'(i);
		end
		pick_i = any_hit ? hit_i : (any_free ? free_i : old_i);
	end

	logic bad;
	assign bad = (len_q == 16'd0) || (32'(len_q) > 32'(BLOCK_BYTES))
		|| (32'(dev_q) >= 32'(DEVICES));

	logic fs_ok;
	assign fs_ok = 32'(fs_q) < 32'(ENTRIES);

	logic [IW-1:0] fs_i;
	assign fs_i = IW'(fs_q);

	logic sync_hit;
	assign sync_hit = st[scan_q].valid && st[scan_q].dirty
		&& (all_q || st[scan_q].dev == dev_q);

	logic        load_out;
	logic [2:0]  n_status;
	logic [3:0]  n_slot, n_vdev;
	logic        n_hit, n_fetch, n_vwb, n_last;
	logic [31:0] n_vblk;
	logic [4:0]  n_cnt;
	logic [15:0] n_bytes;
	logic        scan_step, scan_end;

	always_comb begin
		state_d = state_q;
		in_ready = (state_q == S_IDLE);
		ctl = '0;
		ctl.dev = dev_q;
		ctl.blk = blk_q;
		load_out = 1'b0;
		scan_step = 1'b0;
		scan_end = 1'b0;
		n_status = ST_HIT; n_slot = '0; n_hit = 1'b0; n_fetch = 1'b0;
		n_vwb = 1'b0; n_vdev = '0; n_vblk = '0; n_cnt = '0; n_bytes = '0;
		n_last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = (command == CMD_SYNC) ? S_SYNC : S_LOOKUP;
			end
			S_LOOKUP: begin
				load_out = 1'b1;
				state_d = S_OUT;
				if (cmd_q == CMD_FAIL) begin
					n_status = ST_INVAL;
					n_slot = fs_q;
					if (fs_ok && st[fs_i].valid) begin
						ctl.upd = 1'b1;
						ctl.inval = 1'b1;
						ctl.sel = 6'(fs_i);
						ctl.ref_rank = st[fs_i].rank;
						ctl.sel_was_valid = 1'b1;
					end
				end else if (bad) begin
					n_status = ST_BAD;
				end else begin
					ctl.upd = 1'b1;
					ctl.sel = 6'(pick_i);
					ctl.ref_rank = st[pick_i].rank;
					ctl.sel_was_valid = st[pick_i].valid;
					ctl.set_dirty = (cmd_q == CMD_WRITE);
					ctl.alloc = !any_hit;
					n_slot = 4'(pick_i);
					n_bytes = len_q;
					if (any_hit) begin
						n_status = ST_HIT;
						n_hit = 1'b1;
					end else begin
						n_status = ST_MISS;
						n_fetch = 1'b1;
						if (st[pick_i].valid && st[pick_i].dirty) begin
							n_vwb = 1'b1;
							n_vdev = st[pick_i].dev;
							n_vblk = st[pick_i].blk;
						end
					end
				end
			end
			S_SYNC: begin
				if (!out_valid || out_ready) begin
					scan_step = 1'b1;
					if (sync_hit) begin
						load_out = 1'b1;
						n_status = ST_SYNC_WB;
						n_slot = 4'(scan_q);
						n_vwb = 1'b1;
						n_vdev = st[scan_q].dev;
						n_vblk = st[scan_q].blk;
						n_last = 1'b0;
						ctl.upd = 1'b1;
						ctl.clr_dirty = 1'b1;
						ctl.sel = 6'(scan_q);
					end
					if (32'(scan_q) == 32'(ENTRIES - 1)) begin
						scan_end = 1'b1;
						state_d = S_OUT;
					end
				end
			end
			S_OUT: begin
				if (!out_valid || out_ready) begin
					if (cmd_q == CMD_SYNC && last == 1'b0) begin
						load_out = 1'b1;
						n_status = ST_SYNC_DONE;
						n_cnt = cnt_q;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			last <= 1'b0;
			scan_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid <= 1'b1;
				last <= n_last;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (in_valid && in_ready) begin
				scan_q <= '0;
				cnt_q <= '0;
				// Sync done comes after the last writeback; mark last low to queue it.
				if (command == CMD_SYNC) last <= 1'b0;
			end else begin
				if (scan_step && !scan_end) scan_q <= scan_q + 1'b1;
				if (scan_step && sync_hit) cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			dev_q <= device_id;
			blk_q <= block_number;
			len_q <= length;
			all_q <= sync_all;
			fs_q <= failed_slot;
		end
		if (load_out) begin
			status <= n_status;
			slot <= n_slot;
			hit <= n_hit;
			fetch_needed <= n_fetch;
			victim_writeback <= n_vwb;
			victim_device <= n_vdev;
			victim_block <= n_vblk;
			flush_count <= n_cnt;
			bytes_done <= n_bytes;
		end
	end
endmodule

>>> design/lru_cache_checker.sv
`timescale 1ns / 1ps
module lru_cache_checker
	import lru_cache_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic       hit,
	input logic       fetch_needed,
	input logic       last
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result item dropped while stalled");
	a_hit_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && fetch_needed))
		else $error("hit and fetch both set");
	a_wb_notlast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SYNC_WB |-> !last)
		else $error("sync writeback flagged last");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_SYNC_WB |-> last)
		else $error("final item not flagged last");
	a_in_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid)
		else $error("item accepted while a result item is pending");
endmodule

bind lru_write_back_block_cache_tags_unit lru_cache_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status), .hit(hit),
	.fetch_needed(fetch_needed), .last(last)
);

>>> test/lru_write_back_block_cache_tags_unit_tb.sv
`timescale 1ns / 1ps
module lru_write_back_block_cache_tags_unit_tb;
	import lru_cache_pkg::*;

	localparam int NSLOT = ENTRIES_DEF;
	localparam int BLK_BYTES = BLOCK_BYTES_DEF;
	localparam int NDEV = DEVICES_DEF;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [2:0]  status;
		logic [3:0]  slot;
		logic        hit;
		logic        fetch_needed;
		logic        victim_writeback;
		logic [3:0]  victim_device;
		logic [31:0] victim_block;
		logic [4:0]  flush_count;
		logic [15:0] bytes_done;
		logic        last;
	} tag_result_t;

	class tag_scoreboard;
		bit          valid_q[NSLOT];
		bit          dirty_q[NSLOT];
		logic [3:0]  dev_q[NSLOT];
		logic [31:0] blk_q[NSLOT];
		int          age_q[NSLOT];
		tag_result_t pending_q[$];
		int mismatches;
		int hits, misses, evict_wbs, sync_wbs, syncs, bad_reqs, invals;

		function new();
			for (int i = 0; i < NSLOT; i++) begin
				valid_q[i] = 0;
				dirty_q[i] = 0;
				dev_q[i] = '0;
				blk_q[i] = '0;
				age_q[i] = 0;
			end
			mismatches = 0;
			hits = 0; misses = 0; evict_wbs = 0; sync_wbs = 0;
			syncs = 0; bad_reqs = 0; invals = 0;
		endfunction

		function tag_result_t blank();
			tag_result_t r;
			r = '{default: '0};
			return r;
		endfunction

		// Makes slot s the newest; an invalid slot counts as older than all valid ones.
		function void make_newest(int s);
			int prev;
			prev = valid_q[s] ? age_q[s] : NSLOT;
			for (int j = 0; j < NSLOT; j++)
				if (j != s && valid_q[j] && age_q[j] < prev)
					age_q[j]++;
			age_q[s] = 0;
		endfunction

		function void note_item(cmd_t c, logic [3:0] dev, logic [31:0] blk,
				logic [15:0] len, logic all, logic [3:0] fs);
			tag_result_t r;
			int s, cnt, best;
			r = blank();
			if (c == CMD_SYNC) begin
				cnt = 0;
				syncs++;
				for (int i = 0; i < NSLOT; i++) begin
					if (valid_q[i] && dirty_q[i] && (all || dev_q[i] == dev)) begin
						r = blank();
						r.status = ST_SYNC_WB;
						r.slot = 4'(i);
						r.victim_writeback = 1;
						r.victim_device = dev_q[i];
						r.victim_block = blk_q[i];
						pending_q.push_back(r);
						dirty_q[i] = 0;
						cnt++;
						sync_wbs++;
					end
				end
				r = blank();
				r.status = ST_SYNC_DONE;
				r.flush_count = 5'(cnt);
				r.last = 1;
				pending_q.push_back(r);
				return;
			end
			if (c == CMD_FAIL) begin
				if (fs < NSLOT && valid_q[fs]) begin
					for (int i = 0; i < NSLOT; i++)
						if (i != fs && valid_q[i] && age_q[i] > age_q[fs])
							age_q[i]--;
					valid_q[fs] = 0;
					dirty_q[fs] = 0;
					age_q[fs] = 0;
				end
				invals++;
				r.status = ST_INVAL;
				r.slot = fs;
				r.last = 1;
				pending_q.push_back(r);
				return;
			end
			r.last = 1;
			if (len == 0 || len > BLK_BYTES || dev >= NDEV) begin
				bad_reqs++;
				r.status = ST_BAD;
				pending_q.push_back(r);
				return;
			end
			for (int i = 0; i < NSLOT; i++) begin
				if (valid_q[i] && dev_q[i] == dev && blk_q[i] == blk) begin
					make_newest(i);
					if (c == CMD_WRITE)
						dirty_q[i] = 1;
					hits++;
					r.status = ST_HIT;
					r.slot = 4'(i);
					r.hit = 1;
					r.bytes_done = len;
					pending_q.push_back(r);
					return;
				end
			end
			s = -1;
			for (int i = 0; i < NSLOT; i++)
				if (s < 0 && !valid_q[i])
					s = i;
			if (s < 0) begin
				best = 0;
				for (int i = 1; i < NSLOT; i++)
					if (age_q[i] > age_q[best])
						best = i;
				s = best;
				if (dirty_q[s]) begin
					r.victim_writeback = 1;
					r.victim_device = dev_q[s];
					r.victim_block = blk_q[s];
					evict_wbs++;
				end
			end
			make_newest(s);
			valid_q[s] = 1;
			dirty_q[s] = (c == CMD_WRITE);
			dev_q[s] = dev;
			blk_q[s] = blk;
			misses++;
			r.status = ST_MISS;
			r.slot = 4'(s);
			r.fetch_needed = 1;
			r.bytes_done = len;
			pending_q.push_back(r);
		endfunction

		function void field_check(string name, logic [31:0] exp, logic [31:0] act,
				ref bit bad);
			if (exp !== act) begin
				bad = 1;
				if (mismatches < 10)
					$display("%0t: %s expected %0h got %0h", $time, name, exp, act);
			end
		endfunction

		function void check_result(tag_result_t a);
			tag_result_t e;
			bit bad;
			bad = 0;
			if (pending_q.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result item with nothing expected", $time);
				mismatches++;
				return;
			end
			e = pending_q.pop_front();
			field_check("status", 32'(e.status), 32'(a.status), bad);
			field_check("slot", 32'(e.slot), 32'(a.slot), bad);
			field_check("hit", 32'(e.hit), 32'(a.hit), bad);
			field_check("fetch_needed", 32'(e.fetch_needed), 32'(a.fetch_needed), bad);
			field_check("victim_writeback", 32'(e.victim_writeback),
				32'(a.victim_writeback), bad);
			field_check("victim_device", 32'(e.victim_device), 32'(a.victim_device), bad);
			field_check("victim_block", e.victim_block, a.victim_block, bad);
			field_check("flush_count", 32'(e.flush_count), 32'(a.flush_count), bad);
			field_check("bytes_done", 32'(e.bytes_done), 32'(a.bytes_done), bad);
			field_check("last", 32'(e.last), 32'(a.last), bad);
			if (bad)
				mismatches++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [3:0]  device_id;
	logic [31:0] block_number;
	logic [15:0] length;
	logic        sync_all;
	logic [3:0]  failed_slot;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [3:0]  slot;
	logic        hit;
	logic        fetch_needed;
	logic        victim_writeback;
	logic [3:0]  victim_device;
	logic [31:0] victim_block;
	logic [4:0]  flush_count;
	logic [15:0] bytes_done;
	logic        last;

	tag_scoreboard tags;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	int cycles = 0;
	int items_sent;
	logic [31:0] block_pool[24];

	lru_write_back_block_cache_tags_unit dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		tag_result_t got;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end else if (arst_n) begin
			if (in_valid && in_ready)
				tags.note_item(cmd_t'(command), device_id, block_number, length,
					sync_all, failed_slot);
			if (out_valid && out_ready) begin
				got.status = status;
				got.slot = slot;
				got.hit = hit;
				got.fetch_needed = fetch_needed;
				got.victim_writeback = victim_writeback;
				got.victim_device = victim_device;
				got.victim_block = victim_block;
				got.flush_count = flush_count;
				got.bytes_done = bytes_done;
				got.last = last;
				tags.check_result(got);
			end
		end
	end

	// The receiver; a long hold-off backs the block up onto its input.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_left = 300;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 0;
			end else begin
				out_ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(cmd_t c, logic [3:0] dev, logic [31:0] blk,
			logic [15:0] len, logic all, logic [3:0] fs);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		command = c;
		device_id = dev;
		block_number = blk;
		length = len;
		sync_all = all;
		failed_slot = fs;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_random_item();
		int pick;
		logic [3:0] dev;
		logic [31:0] blk;
		logic [15:0] len;
		pick = $urandom_range(99);
		dev = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(2));
		blk = ($urandom_range(9) == 0) ? $urandom : block_pool[$urandom_range(23)];
		len = ($urandom_range(4) == 0) ? 16'($urandom_range(BLK_BYTES - 8, BLK_BYTES))
			: 16'($urandom_range(1, BLK_BYTES));
		if (pick < 36)
			send_item(CMD_READ, dev, blk, len, 1'($urandom), 4'($urandom));
		else if (pick < 74)
			send_item(CMD_WRITE, dev, blk, len, 1'($urandom), 4'($urandom));
		else if (pick < 82)
			send_item(CMD_SYNC, dev, $urandom, 16'($urandom), 1'($urandom),
				4'($urandom));
		else if (pick < 90)
			send_item(CMD_FAIL, 4'($urandom), $urandom, 16'($urandom), 1'($urandom),
				4'($urandom));
		else if (pick < 95)
			send_item(cmd_t'($urandom_range(1)), dev, blk, 16'd0, 1'($urandom),
				4'($urandom));
		else
			send_item(cmd_t'($urandom_range(1)), dev, blk,
				16'($urandom_range(BLK_BYTES + 1, 65535)), 1'($urandom), 4'($urandom));
	endtask

	initial begin
		tags = new();
		items_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		arst_n = 0;
		in_valid = 0;
		command = CMD_READ;
		device_id = '0;
		block_number = '0;
		length = '0;
		sync_all = 0;
		failed_slot = '0;
		for (int i = 0; i < 24; i++)
			block_pool[i] = $urandom;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: empty sync, a full cache of dirty blocks, eviction, bad lengths, flushes, fill failures.
		send_item(CMD_SYNC, 4'd0, '0, '0, 1'b1, '0);
		send_item(CMD_FAIL, '0, '0, '0, 1'b0, 4'd3);
		for (int i = 0; i < NSLOT; i++)
			send_item(CMD_WRITE, 4'(i), (i == 0) ? 32'd0 : 32'hFFFF_FFF0 + i,
				(i == 1) ? 16'd1 : 16'(BLK_BYTES), 1'b0, '0);
		send_item(CMD_READ, 4'd15, 32'hFFFF_FFFF, 16'd1, 1'b0, '0);
		send_item(CMD_WRITE, 4'd0, 32'd0, 16'd0, 1'b0, '0);
		send_item(CMD_READ, 4'd0, 32'd0, 16'(BLK_BYTES + 1), 1'b0, '0);
		send_item(CMD_READ, 4'd0, 32'd0, 16'hFFFF, 1'b0, '0);
		send_item(CMD_SYNC, 4'd4, '0, '0, 1'b0, '0);
		send_item(CMD_SYNC, 4'd0, '0, '0, 1'b1, '0);
		send_item(CMD_FAIL, '0, '0, '0, 1'b0, 4'd15);
		send_item(CMD_WRITE, 4'd7, 32'h1234_5678, 16'd100, 1'b0, '0);

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 60 : (phase == 3) ? 21 : 0;
			recv_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 21 : 0;
			if (phase == 0)
				hold_req = 1;
			for (int n = 0; n < 77; n++)
				send_random_item();
		end
		in_valid = 0;

		while (tags.pending_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		$display("%0d items: %0d hits, %0d misses, %0d dirty evictions, %0d bad requests",
			items_sent, tags.hits, tags.misses, tags.evict_wbs, tags.bad_reqs);
		$display("%0d syncs flushing %0d blocks, %0d fill-failed items, %0d mismatches",
			tags.syncs, tags.sync_wbs, tags.invals, tags.mismatches);
		if (tags.mismatches == 0 && tags.pending_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
